// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: src/sha_pkg.sv
// SHA-256 package: types, constants and a rotate helper.
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic [5:0] round;
    } round_ctl_t;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_FILL = 6'd56;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: src/sha_if.sv
// Valid/ready channel interfaces for input bytes and digest words.
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
    modport source (output valid, digest_word, word_number, last_word, input ready);
    modport sink (input valid, digest_word, word_number, last_word, output ready);
endinterface

// File: src/sha256_message_digest_top.sv
// SHA-256 message digest: byte packing, padding sequencer and digest output.
// A byte that does not end a block is packed into the block buffer; a byte that fills a
// block starts a compression (a load state, 64 rounds on the shared round unit, a chaining fold).
// The final item adds padding at one byte per cycle outside compressions, one or two
// compressions, then eight output words at one per cycle when the sink is ready.
// rst_n (async, low) restores the initial hash values and clears all counts.
`include "assert_macros.svh"
module sha256_message_digest_top (
    input  logic clk,
    input  logic rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    sha_pkg::state_t state_reg, state_next;
    logic [31:0] block_reg [16];
    logic [31:0] chain_reg [8];
    logic [31:0] work [8];
    logic [5:0]  fill_reg;
    logic [60:0] count_reg;
    logic [5:0]  round_reg;
    logic [2:0]  word_reg;
    logic        final_reg;   // pad byte already placed
    logic        len_reg;     // length words already placed
    logic        tail_reg;    // end of message taken, held until the digest is sent
    sha_pkg::round_ctl_t ctl;

    logic       push;
    logic [7:0] push_byte;
    logic       accept;
    logic [63:0] bit_len;

    sha_round u_round (
        .clk   (clk),
        .ctl   (ctl),
        .block (block_reg),
        .chain (chain_reg),
        .work  (work)
    );

    assign accept  = in_ch.valid && in_ch.ready;
    assign bit_len = {count_reg, 3'b000};
    assign in_ch.ready = (state_reg == sha_pkg::ST_IDLE);
    assign out_ch.valid = (state_reg == sha_pkg::ST_OUT);
    assign out_ch.digest_word = chain_reg[word_reg];
    assign out_ch.word_number = word_reg;
    assign out_ch.last_word = (word_reg == 3'd7);

    // Next state, byte-push and round-start decode.
    always_comb
    begin
        state_next = state_reg;
        push = 1'b0;
        push_byte = 8'h00;
        ctl.start = 1'b0;
        ctl.round = round_reg;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    push = in_ch.byte_present;
                    push_byte = in_ch.data_byte;
                    if (in_ch.byte_present && fill_reg == 6'd63)
                        state_next = sha_pkg::ST_LOAD;
                    else if (in_ch.end_of_message)
                        state_next = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_PAD:
            begin
                if (fill_reg == sha_pkg::LEN_FILL && len_reg)
                begin
                    state_next = sha_pkg::ST_ROUND;
                    ctl.start = 1'b1;
                end
                else if (fill_reg != sha_pkg::LEN_FILL || !len_reg)
                begin
                    push = !(fill_reg == sha_pkg::LEN_FILL && final_reg);
                    push_byte = final_reg ? 8'h00 : sha_pkg::PAD_BYTE;
                    if (push && fill_reg == 6'd63)
                        state_next = sha_pkg::ST_LOAD;
                end
            end
            sha_pkg::ST_LOAD:
            begin
                ctl.start = 1'b1;
                state_next = sha_pkg::ST_ROUND;
            end
            sha_pkg::ST_ROUND:
            begin
                if (round_reg == 6'd63)
                    state_next = sha_pkg::ST_FOLD;
            end
            sha_pkg::ST_FOLD:
            begin
                if (len_reg)
                    state_next = sha_pkg::ST_OUT;
                else if (tail_reg)
                    state_next = sha_pkg::ST_PAD;
                else
                    state_next = sha_pkg::ST_IDLE;
            end
            sha_pkg::ST_OUT:
            begin
                if (out_ch.ready && word_reg == 3'd7)
                    state_next = sha_pkg::ST_IDLE;
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sha_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold counters, chaining words and padding flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            count_reg <= '0;
            round_reg <= '0;
            word_reg  <= '0;
            final_reg <= 1'b0;
            len_reg   <= 1'b0;
            tail_reg  <= 1'b0;
            chain_reg <= sha_pkg::INIT_H;
        end
        else
        begin
            if (push)
                fill_reg <= fill_reg + 6'd1;
            if (accept && in_ch.byte_present)
                count_reg <= count_reg + 61'd1;
            if (accept && in_ch.end_of_message)
                tail_reg <= 1'b1;
            // The pad byte has gone once the first padding push happens.
            if (state_reg == sha_pkg::ST_PAD && push)
                final_reg <= 1'b1;
            if (state_reg == sha_pkg::ST_PAD && fill_reg == sha_pkg::LEN_FILL
                && final_reg && !len_reg)
                len_reg <= 1'b1;
            if (state_reg == sha_pkg::ST_ROUND)
                round_reg <= round_reg + 6'd1;
            if (state_reg == sha_pkg::ST_FOLD)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= chain_reg[i] + work[i];
                if (len_reg)
                    fill_reg <= '0;
            end
            if (state_reg == sha_pkg::ST_OUT && out_ch.ready)
            begin
                word_reg <= word_reg + 3'd1;
                if (word_reg == 3'd7)
                begin
                    chain_reg <= sha_pkg::INIT_H;
                    count_reg <= '0;
                    final_reg <= 1'b0;
                    len_reg   <= 1'b0;
                    tail_reg  <= 1'b0;
                end
            end
        end
    end

    // Write bytes big-endian into the block buffer; place the bit length.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (fill_reg[1:0] == 2'd0)
                block_reg[fill_reg[5:2]] <= {push_byte, 24'h0};
            else
                block_reg[fill_reg[5:2]][(5'd3 - {3'd0, fill_reg[1:0]}) * 8 +: 8]
                    <= push_byte;
        end
        if (state_reg == sha_pkg::ST_PAD && fill_reg == sha_pkg::LEN_FILL
            && final_reg && !len_reg)
        begin
            block_reg[14] <= bit_len[63:32];
            block_reg[15] <= bit_len[31:0];
        end
    end

    `ASSERT_IMPLIES(a_ready_idle, clk, rst_n, in_ch.ready, !out_ch.valid)
    `ASSERT_NEXT(a_round_wrap, clk, rst_n,
        state_reg == sha_pkg::ST_ROUND && round_reg == 6'd63, state_reg == sha_pkg::ST_FOLD)
    `ASSERT_NEXT(a_out_reset, clk, rst_n,
        out_ch.valid && out_ch.ready && out_ch.last_word, chain_reg[0] == sha_pkg::INIT_H[0])
endmodule

// File: src/sha_round.sv
// One SHA-256 round per cycle with a rolling 16-word message schedule.
module sha_round (
    input  logic                clk,
    input  sha_pkg::round_ctl_t ctl,
    input  logic [31:0]         block [16],
    input  logic [31:0]         chain [8],
    output logic [31:0]         work [8]
);
    logic [31:0] sched_reg [16];
    logic [31:0] work_reg [8];
    logic [31:0] w0, w1, w9, w14, s0, s1, wv, t1, t2;
    logic [31:0] a, b, c, d, e, f, g, h;

    // Pick the schedule word (raw for the first 16 rounds, expanded after) and form the round terms.
    always_comb
    begin
        w0  = sched_reg[0];
        w1  = sched_reg[1];
        w9  = sched_reg[9];
        w14 = sched_reg[14];
        s0 = sha_pkg::ror(w1, 7) ^ sha_pkg::ror(w1, 18) ^ (w1 >> 3);
        s1 = sha_pkg::ror(w14, 17) ^ sha_pkg::ror(w14, 19) ^ (w14 >> 10);
        wv = (ctl.round < 6'd16) ? w0 : (w0 + s0 + w9 + s1);
        a = work_reg[0]; b = work_reg[1]; c = work_reg[2]; d = work_reg[3];
        e = work_reg[4]; f = work_reg[5]; g = work_reg[6]; h = work_reg[7];
        t1 = h + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25))
             + ((e & f) ^ (~e & g)) + sha_pkg::ROUND_K[ctl.round] + wv;
        t2 = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22))
             + ((a & b) ^ (a & c) ^ (b & c));
    end

    // Load on start, then shift the schedule and working words each round.
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            sched_reg <= block;
            work_reg  <= chain;
        end
        else
        begin
            for (int i = 0; i < 15; i++)
                sched_reg[i] <= sched_reg[i + 1];
            sched_reg[15] <= wv;
            work_reg[7] <= g;
            work_reg[6] <= f;
            work_reg[5] <= e;
            work_reg[4] <= d + t1;
            work_reg[3] <= c;
            work_reg[2] <= b;
            work_reg[1] <= a;
            work_reg[0] <= t1 + t2;
        end
    end

    assign work = work_reg;
endmodule

// File: sim/sha_tb_if.sv
`timescale 1ns / 1ps
// Scoreboard class that predicts and checks the digest words.
class digest_scoreboard;
    logic [31:0] pending_words[$];
    logic [2:0]  pending_index[$];
    logic        pending_last[$];
    int          mismatches;
    int          words_checked;
    int          messages_seen;

    // State of the digest predictor
    logic [31:0] msg_blk[16];
    logic [5:0]  msg_fill;
    logic [60:0] msg_len;
    logic [31:0] chain[8];

    function void clear_message();
        msg_fill = '0;
        msg_len = '0;
        foreach (chain[i]) chain[i] = sha_pkg::INIT_H[i];
    endfunction

    function new();
        mismatches = 0;
        words_checked = 0;
        messages_seen = 0;
        foreach (msg_blk[i]) msg_blk[i] = '0;
        clear_message();
    endfunction

    function logic [31:0] rot(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Run the 64 rounds over the current block and fold into the chain
    function void compress();
        logic [31:0] w[16];
        logic [31:0] v[8];
        logic [31:0] wv, s0, s1, t1, t2, x15, x2;
        int r;
        w = msg_blk;
        v = chain;
        for (r = 0; r < 64; r++)
        begin
            if (r < 16)
                wv = w[r];
            else
            begin
                x15 = w[(r + 1) & 15];
                x2 = w[(r + 14) & 15];
                s0 = rot(x15, 7) ^ rot(x15, 18) ^ (x15 >> 3);
                s1 = rot(x2, 17) ^ rot(x2, 19) ^ (x2 >> 10);
                wv = w[r & 15] + s0 + w[(r + 9) & 15] + s1;
                w[r & 15] = wv;
            end
            t1 = v[7] + (rot(v[4], 6) ^ rot(v[4], 11) ^ rot(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[r] + wv;
            t2 = (rot(v[0], 2) ^ rot(v[0], 13) ^ rot(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        foreach (chain[i]) chain[i] += v[i];
    endfunction

    function void pack_byte(logic [7:0] b);
        logic [31:0] sh;
        sh = {24'd0, b} << ((3 - msg_fill[1:0]) * 8);
        if (msg_fill[1:0] == 2'd0)
            msg_blk[msg_fill[5:2]] = sh;
        else
            msg_blk[msg_fill[5:2]] |= sh;
        msg_fill = msg_fill + 6'd1;
        if (msg_fill == 6'd0)
            compress();
    endfunction

    // Note one accepted request; queue the digest when it closes a message
    function void note_request(logic [7:0] b, logic present, logic ending);
        logic [63:0] bits;
        if (present)
        begin
            pack_byte(b);
            msg_len = msg_len + 61'd1;
        end
        if (!ending)
            return;
        bits = {msg_len, 3'b000};
        pack_byte(sha_pkg::PAD_BYTE);
        while (msg_fill != sha_pkg::LEN_FILL)
            pack_byte(8'h00);
        msg_blk[14] = bits[63:32];
        msg_blk[15] = bits[31:0];
        compress();
        for (int i = 0; i < 8; i++)
        begin
            pending_words = {pending_words, chain[i]};
            pending_index = {pending_index, i[2:0]};
            pending_last = {pending_last, (i == 7)};
        end
        messages_seen++;
        clear_message();
    endfunction

    function void check_word(logic [31:0] dw, logic [2:0] num, logic lw);
        logic [31:0] ew;
        logic [2:0]  en;
        logic        el;
        if (pending_words.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected digest word %h (number %0d)", dw, num);
            return;
        end
        ew = pending_words.pop_front();
        en = pending_index.pop_front();
        el = pending_last.pop_front();
        words_checked++;
        if (dw !== ew || num !== en || lw !== el)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: digest word exp %h/%0d/%0d got %h/%0d/%0d",
                         ew, en, el, dw, num, lw);
        end
    endfunction
endclass

// File: sim/tb_sha256_message_digest_top.sv
`timescale 1ns / 1ps
// Top-level testbench for the SHA-256 message digest block.
module tb_sha256_message_digest_top;

    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    sha_in_if  in_ch();
    sha_out_if out_ch();

    digest_scoreboard board;
    int  idle_cycles;
    bit  stim_done;
    bit  hold_sink;
    int  requests_sent;

    sha256_message_digest_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // Offer one request and hold it until accepted; drop valid only for a gap
    task automatic send_request(logic [7:0] b, logic present, logic ending);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= b;
        in_ch.byte_present   <= present;
        in_ch.end_of_message <= ending;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        board.note_request(b, present, ending);
        requests_sent++;
    endtask

    // Send a message of n bytes; empty requests sprinkled in when noise is set, end may carry a byte
    task automatic send_message(int n, bit noise);
        int k;
        for (k = 0; k < n; k++)
        begin
            if (noise && $urandom_range(0, 9) == 0)
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            if (k == n - 1 && $urandom_range(0, 1))
            begin
                send_request(8'($urandom_range(0, 255)), 1'b1, 1'b1);
                return;
            end
            send_request(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
        send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic send_fixed(logic [7:0] b, int n);
        for (int k = 0; k < n; k++)
            send_request(b, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_sink)
                out_ch.ready <= 1'b0;
            else if ($urandom_range(0, 3) == 0)
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                out_ch.ready <= 1'b1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Check every accepted digest word
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_word(out_ch.digest_word, out_ch.word_number, out_ch.last_word);
    end

    // Watchdog on cycles with no accepted request or word
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("ERROR: watchdog expired");
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int drained;
        board = new();
        stim_done = 0;
        hold_sink = 0;
        requests_sent = 0;
        rst_n = 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.data_byte      <= '0;
        in_ch.byte_present   <= 1'b0;
        in_ch.end_of_message <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, empty request, "abc", all-ones and zero bytes
        send_request(8'hff, 1'b0, 1'b1);
        send_request(8'h55, 1'b0, 1'b0);
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        send_fixed(8'hff, 3);
        send_fixed(8'h00, 2);
        send_request(8'haa, 1'b1, 1'b1);

        // Long receiver hold-off while messages keep arriving
        fork
            begin
                hold_sink = 1;
                repeat (600) @(posedge clk);
                hold_sink = 0;
            end
            begin
                send_fixed(8'h5a, 1);
                send_fixed(8'ha5, 1);
                send_fixed(8'h3c, 1);
            end
        join

        // Padding boundaries: 55, 56, 63, 64 bytes
        send_message(55, 0);
        send_message(56, 0);
        send_message(63, 0);
        send_message(64, 0);

        // Random messages, mostly short
        while (requests_sent < 350)
        begin
            if ($urandom_range(0, 5) == 0)
                send_message($urandom_range(50, 130), 1);
            else
                send_message($urandom_range(0, 12), 1);
        end
        in_ch.valid <= 1'b0;

        stim_done = 1;
        drained = 0;
        while (board.pending_words.size() != 0 && drained < 100000)
        begin
            @(posedge clk);
            drained++;
        end
        repeat (200) @(posedge clk);

        $display("Covered %0d requests, %0d messages, %0d digest words checked.",
                 requests_sent, board.messages_seen, board.words_checked);
        $display("Messages included empty, padding-boundary and multi-block lengths.");
        if (board.mismatches == 0 && board.pending_words.size() == 0)
            $display("Simulation PASSED");
        else
        begin
            $display("Mismatches: %0d, words outstanding: %0d",
                     board.mismatches, board.pending_words.size());
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+src
src/sha_pkg.sv
src/sha_if.sv
src/sha_round.sv
src/sha256_message_digest_top.sv
sim/sha_tb_if.sv
sim/tb_sha256_message_digest_top.sv
